/* rtl/vrp_pkg.sv */
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared widths, register map, configuration bundle and pipeline payload
// types for the vertex rotate and project unit.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // field widths
    localparam int IN_W      = 15;   // model coordinates, Q.6
    localparam int COEF_W    = 16;   // cos/sin, Q1.14
    localparam int COEF_FRAC = 14;
    localparam int FRAC_W    = 6;    // Q.6 fraction bits
    localparam int DEPTH_W   = 16;
    localparam int YOFF_W    = 10;
    localparam int OUT_W     = 16;   // screen coordinates
    localparam int RZ_W      = 15;   // reported depth

    // internal widths
    localparam int PROD_W    = 36;   // product sums ahead of rounding
    localparam int RC_W      = 21;   // rotated coordinate before saturation
    localparam int DEN_W     = 24;   // signed perspective divisor
    localparam int REM_W     = 23;   // divisor magnitude / remainder
    localparam int QUO_W     = 17;   // quotient magnitude kept
    localparam int DIV_STEPS = QUO_W;
    localparam int SUM_W     = OUT_W + 3;

    // APB map
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic signed [YOFF_W-1:0] X_OFFSET = 10'sd26;
    localparam logic signed [OUT_W-1:0]  OUT_MAX  = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0]  OUT_MIN  = 16'sh8000;

    typedef enum logic [2:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5,
        REG_DEPTH = 3'd6,
        REG_Y_OFF = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0]  cos_x;
        logic signed [COEF_W-1:0]  sin_x;
        logic signed [COEF_W-1:0]  cos_y;
        logic signed [COEF_W-1:0]  sin_y;
        logic signed [COEF_W-1:0]  cos_z;
        logic signed [COEF_W-1:0]  sin_z;
        logic        [DEPTH_W-1:0] depth;
        logic signed [YOFF_W-1:0]  y_off;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cos_x: 16'sd16384, sin_x: 16'sd0,
        cos_y: 16'sd16384, sin_y: 16'sd0,
        cos_z: 16'sd16384, sin_z: 16'sd0,
        depth: 16'd3000,   y_off: 10'sd20
    };

    // rotated vertex handed to the projection
    typedef struct packed {
        logic signed [RC_W-1:0] rx;
        logic signed [RC_W-1:0] ry;
        logic signed [RZ_W-1:0] rz;
    } t_rot_res;

    // one restoring-divider lane
    typedef struct packed {
        logic [REM_W-1:0] rem;   // partial remainder
        logic [QUO_W-1:0] num;   // numerator bits not yet shifted in
        logic [QUO_W-1:0] quo;   // quotient bits so far
        logic             sgn;   // numerator negative
        logic             ovf;   // quotient magnitude does not fit QUO_W
    } t_div_lane;

    typedef struct packed {
        t_div_lane              lx;
        t_div_lane              ly;
        logic [REM_W-1:0]       dmag;
        logic                   zero;
        logic                   den_neg;
        logic signed [RZ_W-1:0] rz;
    } t_div_work;

endpackage

/* rtl/vrp_rotate.sv */
// ----------------------------------------------------------------------------
// vrp_rotate
// Three-stage rotation pipeline: Y, then Z, then X, each stage rounding the
// Q1.14 products back to Q.6.
// ----------------------------------------------------------------------------
module vrp_rotate
    import vrp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [IN_W-1:0] i_x,
    input  logic signed [IN_W-1:0] i_y,
    input  logic signed [IN_W-1:0] i_z,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_rot_res               o_res
);

    localparam int TX_W = 18;
    localparam int TB_W = 19;
    localparam logic signed [RC_W-1:0] RZ_HI = 21'sd16383;
    localparam logic signed [RC_W-1:0] RZ_LO = -21'sd16384;

    // floor((v + 2^13) / 2^14)
    function automatic logic signed [PROD_W-COEF_FRAC-1:0] round_q14(
        input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] w;
        w = v + PROD_W'(1 << (COEF_FRAC - 1));
        return w[PROD_W-1:COEF_FRAC];
    endfunction

    logic r_v1, r_v2, r_v3;
    logic st1, st2, st3;

    logic signed [TX_W-1:0] r1_tx, r1_tz, n_tx, n_tz;
    logic signed [IN_W-1:0] r1_y;
    logic signed [TX_W-1:0] r2_tz;
    logic signed [TB_W-1:0] r2_ty, r2_rx, n_ty, n_rx;
    logic signed [RC_W-1:0] n_ry, n_rz_full;
    t_rot_res               r_res, n_res;

    assign st3     = r_v3 & i_stall;
    assign st2     = r_v2 & st3;
    assign st1     = r_v1 & st2;
    assign o_stall = st1;

    always_comb begin
        // about Y
        n_tx = TX_W'(round_q14(PROD_W'(i_cfg.cos_y) * PROD_W'(i_x)
                             - PROD_W'(i_cfg.sin_y) * PROD_W'(i_z)));
        n_tz = TX_W'(round_q14(PROD_W'(i_cfg.sin_y) * PROD_W'(i_x)
                             + PROD_W'(i_cfg.cos_y) * PROD_W'(i_z)));
        // about Z
        n_ty = TB_W'(round_q14(PROD_W'(i_cfg.cos_z) * PROD_W'(r1_y)
                             - PROD_W'(i_cfg.sin_z) * PROD_W'(r1_tx)));
        n_rx = TB_W'(round_q14(PROD_W'(i_cfg.cos_z) * PROD_W'(r1_tx)
                             + PROD_W'(i_cfg.sin_z) * PROD_W'(r1_y)));
        // about X
        n_ry      = RC_W'(round_q14(PROD_W'(i_cfg.sin_x) * PROD_W'(r2_tz)
                                  + PROD_W'(i_cfg.cos_x) * PROD_W'(r2_ty)));
        n_rz_full = RC_W'(round_q14(PROD_W'(i_cfg.cos_x) * PROD_W'(r2_tz)
                                  - PROD_W'(i_cfg.sin_x) * PROD_W'(r2_ty)));
        n_res.rx = RC_W'(r2_rx);
        n_res.ry = n_ry;
        if (n_rz_full > RZ_HI) begin
            n_res.rz = RZ_W'(RZ_HI);
        end else if (n_rz_full < RZ_LO) begin
            n_res.rz = RZ_W'(RZ_LO);
        end else begin
            n_res.rz = n_rz_full[RZ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!st1) r_v1 <= i_valid;
            if (!st2) r_v2 <= r_v1;
            if (!st3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st1) begin
            r1_tx <= n_tx;
            r1_tz <= n_tz;
            r1_y  <= i_y;
        end
        if (!st2) begin
            r2_tz <= r1_tz;
            r2_ty <= n_ty;
            r2_rx <= n_rx;
        end
        if (!st3) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

/* rtl/vrp_div_array.sv */
// ----------------------------------------------------------------------------
// vrp_div_array
// Pipelined restoring divider, one quotient bit per stage, two numerator
// lanes sharing one divisor magnitude.
// ----------------------------------------------------------------------------
module vrp_div_array
    import vrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_div_work i_work,
    output logic      o_valid,
    input  logic      i_stall,
    output t_div_work o_work
);

    function automatic t_div_lane lane_step(input t_div_lane l,
                                            input logic [REM_W-1:0] d);
        logic [REM_W:0] sh;
        logic           ge;
        t_div_lane      r;
        r  = l;
        sh = {l.rem, l.num[QUO_W-1]};
        ge = (sh >= {1'b0, d});
        r.rem = ge ? REM_W'(sh - {1'b0, d}) : sh[REM_W-1:0];
        r.num = {l.num[QUO_W-2:0], 1'b0};
        r.quo = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    function automatic t_div_work work_step(input t_div_work w);
        t_div_work r;
        r    = w;
        r.lx = lane_step(w.lx, w.dmag);
        r.ly = lane_step(w.ly, w.dmag);
        return r;
    endfunction

    logic      vld_chain  [DIV_STEPS+1];
    t_div_work work_chain [DIV_STEPS+1];
    logic      stall_chain[DIV_STEPS+1];

    assign vld_chain[0]          = i_valid;
    assign work_chain[0]         = i_work;
    assign stall_chain[DIV_STEPS] = i_stall;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic      r_vld;
        t_div_work r_work;

        assign stall_chain[k] = r_vld & stall_chain[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (!stall_chain[k]) begin
                r_vld <= vld_chain[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!stall_chain[k]) begin
                r_work <= work_step(work_chain[k]);
            end
        end

        assign vld_chain[k+1]  = r_vld;
        assign work_chain[k+1] = r_work;
    end

    assign o_stall = stall_chain[0];
    assign o_valid = vld_chain[DIV_STEPS];
    assign o_work  = work_chain[DIV_STEPS];

endmodule

/* rtl/vrp_project.sv */
// ----------------------------------------------------------------------------
// vrp_project
// Perspective projection: divisor setup stage, divider array, then sign,
// screen offset and saturation into the output register.
// ----------------------------------------------------------------------------
module vrp_project
    import vrp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_rot_res                i_res,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_screen_x,
    output logic signed [OUT_W-1:0] o_screen_y,
    output logic signed [RZ_W-1:0]  o_rotated_z,
    output logic                    o_divide_fault
);

    localparam int PRE_SH = QUO_W - COEF_FRAC;   // numerator bits after the top ones
    localparam int OVF_W  = REM_W + PRE_SH;

    function automatic t_div_lane prep_lane(input logic signed [RC_W-1:0] v,
                                            input logic [REM_W-1:0] dmag);
        logic [RC_W-1:0] mag;
        t_div_lane       l;
        mag   = v[RC_W-1] ? RC_W'(-v) : RC_W'(v);
        l.rem = REM_W'(mag[RC_W-1:PRE_SH]);
        l.num = {mag[PRE_SH-1:0], {COEF_FRAC{1'b0}}};
        l.quo = '0;
        l.sgn = v[RC_W-1];
        // quotient >= 2^QUO_W exactly when |v| >= 2^PRE_SH * |D|
        l.ovf = (OVF_W'(mag) >= {dmag, {PRE_SH{1'b0}}});
        return l;
    endfunction

    function automatic logic signed [OUT_W-1:0] finish_lane(
        input t_div_lane l, input logic den_neg, input logic zero,
        input logic signed [YOFF_W-1:0] off);
        logic        [QUO_W-1:0] qmag;
        logic signed [QUO_W:0]   q;
        logic signed [SUM_W-1:0] sum;
        logic signed [OUT_W-1:0] res;
        qmag = l.ovf ? '1 : l.quo;
        q    = (l.sgn ^ den_neg) ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        sum  = SUM_W'(q) + SUM_W'($signed({off, {FRAC_W{1'b0}}}));
        if (zero) begin
            res = l.sgn ? OUT_MIN : OUT_MAX;
        end else if (sum > SUM_W'(OUT_MAX)) begin
            res = OUT_MAX;
        end else if (sum < SUM_W'(OUT_MIN)) begin
            res = OUT_MIN;
        end else begin
            res = sum[OUT_W-1:0];
        end
        return res;
    endfunction

    logic                    r_p_vld, p_stall, div_stall, div_vld, out_stall;
    t_div_work               r_p_work, n_p_work, div_work;
    logic signed [DEN_W-1:0] n_d;

    logic                    r_o_vld;
    logic signed [OUT_W-1:0] r_sx, r_sy;
    logic signed [RZ_W-1:0]  r_rz;
    logic                    r_fault;

    assign out_stall = r_o_vld & i_stall;
    assign p_stall   = r_p_vld & div_stall;
    assign o_stall   = p_stall;

    // divisor 2*rz - depth*64, magnitude and sign for the divider
    always_comb begin
        n_d = ($signed(DEN_W'(i_res.rz)) <<< 1)
            - $signed(DEN_W'({i_cfg.depth, {FRAC_W{1'b0}}}));
        n_p_work.dmag    = n_d[DEN_W-1] ? REM_W'(-n_d) : REM_W'(n_d);
        n_p_work.zero    = (n_d == '0);
        n_p_work.den_neg = n_d[DEN_W-1];
        n_p_work.rz      = i_res.rz;
        n_p_work.lx      = prep_lane(i_res.rx, n_p_work.dmag);
        n_p_work.ly      = prep_lane(i_res.ry, n_p_work.dmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (!p_stall)   r_p_vld <= i_valid;
            if (!out_stall) r_o_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!p_stall) begin
            r_p_work <= n_p_work;
        end
        if (!out_stall) begin
            r_sx    <= finish_lane(div_work.lx, div_work.den_neg, div_work.zero, X_OFFSET);
            r_sy    <= finish_lane(div_work.ly, div_work.den_neg, div_work.zero,
                                   i_cfg.y_off);
            r_rz    <= div_work.rz;
            r_fault <= div_work.zero;
        end
    end

    vrp_div_array u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_vld),
        .o_stall (div_stall),
        .i_work  (r_p_work),
        .o_valid (div_vld),
        .i_stall (out_stall),
        .o_work  (div_work)
    );

    assign o_valid        = r_o_vld;
    assign o_screen_x     = r_sx;
    assign o_screen_y     = r_sy;
    assign o_rotated_z    = r_rz;
    assign o_divide_fault = r_fault;

endmodule

/* rtl/vertex_rotate_project_unit.sv */
// ----------------------------------------------------------------------------
// vertex_rotate_project_unit
// Rotates a Q.6 model vertex about Y, Z and X and projects it to screen space.
//
//   channel  direction  handshake          payload
//   vertex   in         i_valid / o_stall  i_model_x, i_model_y, i_model_z
//   result   out        o_valid / i_stall  o_screen_x, o_screen_y,
//                                          o_rotated_z, o_divide_fault
//   config   in         APB psel/penable   paddr, pwdata, prdata
//
// One vertex per cycle sustained while the output is not stalled; a vertex
// passes through three rotation stages, one divisor setup stage, the 17-stage
// restoring divider (one quotient bit per stage), and the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// identity rotation, depth 3000 and y offset 20.
// A stalled output only backs up as far as needed: empty stages keep filling,
// so o_stall rises only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module vertex_rotate_project_unit
    import vrp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // vertex in
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [IN_W-1:0]  i_model_x,
    input  logic signed [IN_W-1:0]  i_model_y,
    input  logic signed [IN_W-1:0]  i_model_z,
    // result out
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_screen_x,
    output logic signed [OUT_W-1:0] o_screen_y,
    output logic signed [RZ_W-1:0]  o_rotated_z,
    output logic                    o_divide_fault,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     rot_vld, rot_stall;
    t_rot_res rot_res;

    // registers sit on 32-bit words; byte lanes in paddr[1:0] are ignored
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COS_X: r_cfg.cos_x <= $signed(pwdata[COEF_W-1:0]);
                REG_SIN_X: r_cfg.sin_x <= $signed(pwdata[COEF_W-1:0]);
                REG_COS_Y: r_cfg.cos_y <= $signed(pwdata[COEF_W-1:0]);
                REG_SIN_Y: r_cfg.sin_y <= $signed(pwdata[COEF_W-1:0]);
                REG_COS_Z: r_cfg.cos_z <= $signed(pwdata[COEF_W-1:0]);
                REG_SIN_Z: r_cfg.sin_z <= $signed(pwdata[COEF_W-1:0]);
                REG_DEPTH: r_cfg.depth <= pwdata[DEPTH_W-1:0];
                REG_Y_OFF: r_cfg.y_off <= $signed(pwdata[YOFF_W-1:0]);
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    // read back raw register bits, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_COS_X: prdata = DATA_W'(unsigned'(r_cfg.cos_x));
            REG_SIN_X: prdata = DATA_W'(unsigned'(r_cfg.sin_x));
            REG_COS_Y: prdata = DATA_W'(unsigned'(r_cfg.cos_y));
            REG_SIN_Y: prdata = DATA_W'(unsigned'(r_cfg.sin_y));
            REG_COS_Z: prdata = DATA_W'(unsigned'(r_cfg.cos_z));
            REG_SIN_Z: prdata = DATA_W'(unsigned'(r_cfg.sin_z));
            REG_DEPTH: prdata = DATA_W'(r_cfg.depth);
            REG_Y_OFF: prdata = DATA_W'(unsigned'(r_cfg.y_off));
            default:   prdata = '0;
        endcase
    end

    // rotation: Y, Z, X, one axis per stage
    vrp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_x     (i_model_x),
        .i_y     (i_model_y),
        .i_z     (i_model_z),
        .o_valid (rot_vld),
        .i_stall (rot_stall),
        .o_res   (rot_res)
    );

    // perspective divide, offsets, saturation, output register
    vrp_project u_project (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (rot_vld),
        .o_stall        (rot_stall),
        .i_res          (rot_res),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_rotated_z    (o_rotated_z),
        .o_divide_fault (o_divide_fault)
    );

`ifndef NO_ASSERTIONS
    // a zero divisor always pins both screen coordinates to a rail
    a_fault_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_fault) |->
            ((o_screen_x == OUT_MAX || o_screen_x == OUT_MIN) &&
             (o_screen_y == OUT_MAX || o_screen_y == OUT_MIN)))
        else $error("divide fault without saturated screen coordinates");

    // input backpressure only when a result is held at a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule
